// ----- hw/rtl/deadline_timer_queue_top_defines.svh -----
// Assertion macros for the deadline timer queue checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef DEADLINE_TIMER_QUEUE_TOP_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_TOP_DEFINES_SVH

// same-cycle implication
`define DTQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtq check failed");

// next-cycle implication
`define DTQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtq check failed");

`endif

// ----- hw/rtl/dtq_pkg.sv -----
// Shared constants, codes and types of the deadline timer queue.
// No dependencies.
package dtq_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int FRAME_SLOTS = 16;
  localparam int MAX_RESULTS = 16;

  localparam int MAX_SLOTS = (TIMER_SLOTS > FRAME_SLOTS) ? TIMER_SLOTS : FRAME_SLOTS;
  localparam int CW        = $clog2(MAX_SLOTS + 1);
  localparam int KW        = $clog2(MAX_RESULTS);
  localparam int PEND_W    = 5;
  localparam int TIME_W    = 64;
  localparam int TAG_W     = 16;
  localparam int DELAY_W   = 32;

  localparam logic [1:0] K_SCHED  = 2'd0;
  localparam logic [1:0] K_FSCHED = 2'd1;
  localparam logic [1:0] K_TICK   = 2'd2;
  localparam logic [1:0] K_NFRAME = 2'd3;

  localparam logic [1:0] EV_ACCEPTED = 2'd0;
  localparam logic [1:0] EV_REJECTED = 2'd1;
  localparam logic [1:0] EV_TIMER    = 2'd2;
  localparam logic [1:0] EV_FRAME    = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] dl;
    logic [TAG_W-1:0]  tag;
  } tq_ent_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } tq_ctl_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fq_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_INS    = 4'b0010,
    S_TICK   = 4'b0100,
    S_NFRAME = 4'b1000
  } state_t;

  function automatic logic [PEND_W-1:0] pend_sat(input logic [CW-1:0] c);
    logic [PEND_W-1:0] r;
    if (int'(c) > 31) r = '1;
    else              r = PEND_W'(c);
    return r;
  endfunction

endpackage

// ----- hw/rtl/dtq_tcell.sv -----
// One cell of the sorted timer chain: a deadline and a tag.
// Depends on dtq_pkg.
module dtq_tcell (
  input  logic                          clk,
  input  dtq_pkg::tq_ctl_t              ctl,
  input  logic                          occ,
  input  logic                          prev_keep,
  input  logic [dtq_pkg::TIME_W-1:0]    ins_dl,
  input  logic [dtq_pkg::TAG_W-1:0]     ins_tag,
  input  dtq_pkg::tq_ent_t              prev_ent,
  input  dtq_pkg::tq_ent_t              next_ent,
  output dtq_pkg::tq_ent_t              ent,
  output logic                          keep
);

  dtq_pkg::tq_ent_t ent_r;
  dtq_pkg::tq_ent_t ent_nxt;

  assign keep = occ && (ent_r.dl <= ins_dl);
  assign ent  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins && !keep) begin
      if (prev_keep) begin
        ent_nxt.dl  = ins_dl;
        ent_nxt.tag = ins_tag;
      end else begin
        ent_nxt = prev_ent;
      end
    end else if (ctl.pop) begin
      ent_nxt = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ----- hw/rtl/dtq_fcell.sv -----
// One cell of the next-frame chain: a single tag.
// Depends on dtq_pkg.
module dtq_fcell (
  input  logic                       clk,
  input  dtq_pkg::fq_ctl_t           ctl,
  input  logic                       wr_sel,
  input  logic [dtq_pkg::TAG_W-1:0]  ins_tag,
  input  logic [dtq_pkg::TAG_W-1:0]  next_tag,
  output logic [dtq_pkg::TAG_W-1:0]  tag
);

  logic [dtq_pkg::TAG_W-1:0] tag_r;
  logic [dtq_pkg::TAG_W-1:0] tag_nxt;

  assign tag = tag_r;

  always_comb begin
    tag_nxt = tag_r;
    if (ctl.push && wr_sel) tag_nxt = ins_tag;
    else if (ctl.pop)       tag_nxt = next_tag;
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

endmodule

// ----- hw/rtl/deadline_timer_queue_top.sv -----
// Deadline timer queue: sorted timer chain plus next-frame chain.
// Depends on dtq_pkg, dtq_tcell and dtq_fcell.
//
// Usage:
//   Input items arrive on in_tvalid/in_tready. in_tuser carries the kind
//   (schedule after delay, schedule next frame, tick, new frame); in_tdata
//   carries the signed delay and the tag.
//   Results leave on out_tvalid/out_tready with the event code in out_tuser,
//   the tag and both pending counts in out_tdata, and out_tlast on the last
//   result of an item.
//   A frame-schedule item is answered in the cycle after acceptance; a timer
//   schedule is a deadline add, then a sorted insert across the cell chain.
//   A tick advances time on acceptance and then fires one due timer per
//   cycle from the head of the chain, up to 16; a new frame fires one listed
//   tag per cycle, up to 16; both pause while the output is stalled. A tick
//   with nothing due, or a new frame with an empty list, gives no result.
//   One item is worked on at a time; the next is taken once the previous one
//   is done and the output register is free or being emptied.
//   Reset clears time, both counts and the output valid flag.
//   A stalled receiver holds the output register and freezes the queue.
module deadline_timer_queue_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // delay[31:0], tag[47:32]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // tag_res[15:0], pending_timers[20:16],
                                  // pending_frame[25:21], zero[31:26]
  output logic [1:0]  out_tuser,  // event_res[1:0]
  output logic        out_tlast
);

  localparam int TS = dtq_pkg::TIMER_SLOTS;
  localparam int FS = dtq_pkg::FRAME_SLOTS;
  localparam int CW = dtq_pkg::CW;
  localparam int KW = dtq_pkg::KW;
  localparam int TW = dtq_pkg::TIME_W;
  localparam int GW = dtq_pkg::TAG_W;
  localparam int PW = dtq_pkg::PEND_W;

  dtq_pkg::state_t     state_r, state_nxt;
  logic [TW-1:0]       time_r, time_nxt;
  logic [CW-1:0]       tcount_r, tcount_nxt;
  logic [CW-1:0]       fcount_r, fcount_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  logic [TW-1:0]       sdl_r, sdl_nxt;
  logic [GW-1:0]       stag_r, stag_nxt;

  logic                out_vld_r, out_vld_nxt;
  logic [1:0]          out_ev_r, out_ev_nxt;
  logic [GW-1:0]       out_tag_r, out_tag_nxt;
  logic                out_last_r, out_last_nxt;
  logic [PW-1:0]       out_pt_r, out_pt_nxt;
  logic [PW-1:0]       out_pf_r, out_pf_nxt;

  logic                out_free, in_acc, emit;
  logic [1:0]          kind;
  logic [GW-1:0]       in_tag;
  logic [31:0]         in_delay;
  logic [31:0]         dpos;
  logic [TW:0]         dl_sum;
  logic                due0, due1;

  dtq_pkg::tq_ctl_t    tctl;
  dtq_pkg::fq_ctl_t    fctl;
  dtq_pkg::tq_ent_t    tent [TS];
  logic                tkeep [TS];
  logic [GW-1:0]       ftag [FS];

  assign kind     = in_tuser;
  assign in_delay = in_tdata[31:0];
  assign in_tag   = in_tdata[47:32];
  assign dpos     = in_delay[31] ? 32'd0 : in_delay;
  assign dl_sum   = {1'b0, time_r} + {{(TW-31){1'b0}}, dpos};

  assign out_free  = !out_vld_r || out_tready;
  assign in_tready = (state_r == dtq_pkg::S_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  assign due0 = (tcount_r != '0) && (tent[0].dl <= time_r);
  assign due1 = (tcount_r > CW'(1)) && (tent[1].dl <= time_r);

  genvar gi;
  generate
    for (gi = 0; gi < TS; gi++) begin : g_tcell
      dtq_pkg::tq_ent_t prev_e, next_e;
      logic             prev_k;
      if (gi == 0) begin : g_first
        assign prev_e = '0;
        assign prev_k = 1'b1;
      end else begin : g_mid
        assign prev_e = tent[gi-1];
        assign prev_k = tkeep[gi-1];
      end
      if (gi == TS - 1) begin : g_end
        assign next_e = '0;
      end else begin : g_nxt
        assign next_e = tent[gi+1];
      end
      dtq_tcell u_tcell (
        .clk       (clk),
        .ctl       (tctl),
        .occ       (CW'(gi) < tcount_r),
        .prev_keep (prev_k),
        .ins_dl    (sdl_r),
        .ins_tag   (stag_r),
        .prev_ent  (prev_e),
        .next_ent  (next_e),
        .ent       (tent[gi]),
        .keep      (tkeep[gi])
      );
    end

    for (gi = 0; gi < FS; gi++) begin : g_fcell
      logic [GW-1:0] next_t;
      if (gi == FS - 1) begin : g_end
        assign next_t = '0;
      end else begin : g_nxt
        assign next_t = ftag[gi+1];
      end
      dtq_fcell u_fcell (
        .clk      (clk),
        .ctl      (fctl),
        .wr_sel   (CW'(gi) == fcount_r),
        .ins_tag  (in_tag),
        .next_tag (next_t),
        .tag      (ftag[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt    = state_r;
    time_nxt     = time_r;
    tcount_nxt   = tcount_r;
    fcount_nxt   = fcount_r;
    k_nxt        = k_r;
    sdl_nxt      = sdl_r;
    stag_nxt     = stag_r;
    tctl         = '0;
    fctl         = '0;
    emit         = 1'b0;
    out_ev_nxt   = out_ev_r;
    out_tag_nxt  = out_tag_r;
    out_last_nxt = out_last_r;

    case (state_r)
      dtq_pkg::S_IDLE: begin
        if (in_acc) begin
          case (kind)
            dtq_pkg::K_SCHED: begin
              sdl_nxt   = dl_sum[TW] ? '1 : dl_sum[TW-1:0];
              stag_nxt  = in_tag;
              state_nxt = dtq_pkg::S_INS;
            end
            dtq_pkg::K_FSCHED: begin
              emit         = 1'b1;
              out_tag_nxt  = in_tag;
              out_last_nxt = 1'b1;
              if (fcount_r == CW'(FS)) begin
                out_ev_nxt = dtq_pkg::EV_REJECTED;
              end else begin
                out_ev_nxt = dtq_pkg::EV_ACCEPTED;
                fctl.push  = 1'b1;
                fcount_nxt = fcount_r + CW'(1);
              end
            end
            dtq_pkg::K_TICK: begin
              time_nxt  = (&time_r) ? time_r : time_r + TW'(1);
              k_nxt     = '0;
              state_nxt = dtq_pkg::S_TICK;
            end
            default: begin
              k_nxt     = '0;
              state_nxt = dtq_pkg::S_NFRAME;
            end
          endcase
        end
      end
      dtq_pkg::S_INS: begin
        if (out_free) begin
          emit         = 1'b1;
          out_tag_nxt  = stag_r;
          out_last_nxt = 1'b1;
          state_nxt    = dtq_pkg::S_IDLE;
          if (tcount_r == CW'(TS)) begin
            out_ev_nxt = dtq_pkg::EV_REJECTED;
          end else begin
            out_ev_nxt = dtq_pkg::EV_ACCEPTED;
            tctl.ins   = 1'b1;
            tcount_nxt = tcount_r + CW'(1);
          end
        end
      end
      dtq_pkg::S_TICK: begin
        if (!due0) begin
          state_nxt = dtq_pkg::S_IDLE;
        end else if (out_free) begin
          emit         = 1'b1;
          out_ev_nxt   = dtq_pkg::EV_TIMER;
          out_tag_nxt  = tent[0].tag;
          out_last_nxt = (k_r == KW'(dtq_pkg::MAX_RESULTS - 1)) || !due1;
          tctl.pop     = 1'b1;
          tcount_nxt   = tcount_r - CW'(1);
          k_nxt        = k_r + KW'(1);
          if (out_last_nxt) state_nxt = dtq_pkg::S_IDLE;
        end
      end
      dtq_pkg::S_NFRAME: begin
        if (fcount_r == '0) begin
          state_nxt = dtq_pkg::S_IDLE;
        end else if (out_free) begin
          emit         = 1'b1;
          out_ev_nxt   = dtq_pkg::EV_FRAME;
          out_tag_nxt  = ftag[0];
          out_last_nxt = (k_r == KW'(dtq_pkg::MAX_RESULTS - 1)) ||
                         (fcount_r == CW'(1));
          fctl.pop     = 1'b1;
          fcount_nxt   = fcount_r - CW'(1);
          k_nxt        = k_r + KW'(1);
          if (out_last_nxt) state_nxt = dtq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dtq_pkg::S_IDLE;
      end
    endcase

    out_pt_nxt  = emit ? dtq_pkg::pend_sat(tcount_nxt) : out_pt_r;
    out_pf_nxt  = emit ? dtq_pkg::pend_sat(fcount_nxt) : out_pf_r;
    out_vld_nxt = emit ? 1'b1 : (out_vld_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= dtq_pkg::S_IDLE;
      time_r    <= '0;
      tcount_r  <= '0;
      fcount_r  <= '0;
      k_r       <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      time_r    <= time_nxt;
      tcount_r  <= tcount_nxt;
      fcount_r  <= fcount_nxt;
      k_r       <= k_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sdl_r      <= sdl_nxt;
    stag_r     <= stag_nxt;
    out_ev_r   <= out_ev_nxt;
    out_tag_r  <= out_tag_nxt;
    out_last_r <= out_last_nxt;
    out_pt_r   <= out_pt_nxt;
    out_pf_r   <= out_pf_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_ev_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, out_pf_r, out_pt_r, out_tag_r};

endmodule

// ----- hw/rtl/dtq_checker.sv -----
// Port-level checks of the deadline timer queue, bound to the top level.
// Depends on dtq_pkg and deadline_timer_queue_top_defines.svh.
`include "deadline_timer_queue_top_defines.svh"

module dtq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [47:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  `DTQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  `DTQ_ASSERT_NEXT(a_fsched_reply, in_tvalid && in_tready && (in_tuser == dtq_pkg::K_FSCHED), out_tvalid && out_tlast && (out_tdata[15:0] == $past(in_tdata[47:32])) && ((out_tuser == dtq_pkg::EV_ACCEPTED) || (out_tuser == dtq_pkg::EV_REJECTED)))

  `DTQ_ASSERT_NOW(a_burst_blocks_in, out_tvalid && !out_tlast, !in_tready)

  `DTQ_ASSERT_NOW(a_fire_not_last_busy, out_tvalid && !out_tlast, (out_tuser == dtq_pkg::EV_TIMER) || (out_tuser == dtq_pkg::EV_FRAME))

endmodule

bind deadline_timer_queue_top dtq_checker u_dtq_checker (.*);
